[rtl/core/abst_pkg.sv]
`timescale 1ns / 1ps

package abst_pkg;

    // Operation codes of an input item.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FETCH  = 1'b1;

    // Traversal orders selected by the order register.
    localparam logic [1:0] ORD_IN    = 2'd0;
    localparam logic [1:0] ORD_PRE   = 2'd1;
    localparam logic [1:0] ORD_POST  = 2'd2;
    localparam logic [1:0] ORD_LEVEL = 2'd3;

    // Result status codes.
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_DROP = 2'd1;
    localparam logic [1:0] STAT_END  = 2'd2;

    // Controller states.
    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_WAIT,
        S_INS,
        S_ROOT,
        S_FC,
        S_PDA,
        S_PDB,
        S_KEY,
        S_NEXT,
        S_INX,
        S_INUP,
        S_PRA,
        S_PRB,
        S_PRUP,
        S_PRC,
        S_PO,
        S_POX,
        S_LVSTEP,
        S_LV,
        S_EMIT
    } t_state;

    // Source of the probe index.
    typedef enum logic [3:0] {
        J_HOLD,
        J_ZERO,
        J_CHILD_INS,
        J_2J1,
        J_2J2,
        J_2I1,
        J_IM1,
        J_I,
        J_NEXT,
        J_LEVEL
    } t_jsel;

    // Source of the working index.
    typedef enum logic [1:0] {
        I_HOLD,
        I_J,
        I_P
    } t_isel;

    // Source of the stored following slot.
    typedef enum logic [2:0] {
        N_HOLD,
        N_I,
        N_J,
        N_P,
        N_NONE
    } t_nsel;

    // Result register load.
    typedef enum logic [1:0] {
        O_HOLD,
        O_INSERT,
        O_END,
        O_KEY
    } t_osel;

    typedef struct packed {
        t_jsel jsel;
        t_isel isel;
        t_nsel nsel;
        t_osel osel;
        logic  key_load;
        logic  kbuf_load;
        logic  clear_en;
    } t_ctl;

    typedef struct packed {
        logic occ;
        logic j_in_range;
        logic i_zero;
        logic i_even;
        logic lv_end;
        logic next_none;
        logic clr_last;
    } t_stat;

endpackage

[rtl/core/abst_datapath.sv]
`timescale 1ns / 1ps

module abst_datapath
    import abst_pkg::*;
#(
    parameter int NODES     = 2048,
    parameter int KEY_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctl               i_ctl,
    input  logic signed [31:0] i_key,
    output t_stat              o_stat,
    output logic signed [31:0] o_out_key,
    output logic [1:0]         o_status,
    output logic               o_last
);

    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int IW = $clog2(NODES) + 3;
    localparam logic [IW-1:0] LIM  = IW'(NODES);
    localparam logic [IW-1:0] TOPJ = IW'(NODES - 1);
    localparam logic [IW-1:0] LB   = IW'((1 << $clog2(NODES + 1)) - 1);

    // Slot store: valid bit on top of the key.
    logic [KEY_WIDTH:0] r_mem [NODES];
    logic [KEY_WIDTH:0] r_q;

    logic [IW-1:0]  r_j, n_j;
    logic [IW-1:0]  r_i, n_i;
    logic [IW-1:0]  r_next;
    logic           r_next_none;
    logic [AW-1:0]  r_clr;
    logic signed [KEY_WIDTH-1:0] r_key;
    logic signed [KEY_WIDTH-1:0] r_kbuf;
    logic signed [31:0] r_out_key;
    logic [1:0]     r_status;
    logic           r_last;

    logic [IW-1:0]  par;
    logic [IW-1:0]  j_child;
    logic [IW-1:0]  lv_raw;
    logic [IW-1:0]  lv_j;
    logic           is_base;
    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    logic [KEY_WIDTH:0] mem_wd;

    // Index arithmetic shared by all walks.
    always_comb begin
        par     = (r_i - IW'(1)) >> 1;
        j_child = ($signed(r_q[KEY_WIDTH-1:0]) < r_key) ?
                  {r_j[IW-2:0], 1'b0} + IW'(2) : {r_j[IW-2:0], 1'b0} + IW'(1);
        is_base = ((r_j + IW'(1)) & r_j) == '0;
        lv_raw  = is_base ? {r_j[IW-3:0], 2'b00} + IW'(2) : r_j - IW'(1);
        lv_j    = (lv_raw >= LIM) ? TOPJ : lv_raw;
    end

    // Status back to the controller.
    always_comb begin
        o_stat.occ        = (r_j < LIM) && r_q[KEY_WIDTH];
        o_stat.j_in_range = r_j < LIM;
        o_stat.i_zero     = r_i == '0;
        o_stat.i_even     = ~r_i[0];
        o_stat.lv_end     = lv_raw >= LB;
        o_stat.next_none  = r_next_none;
        o_stat.clr_last   = r_clr == AW'(NODES - 1);
    end

    // Next probe and working index.
    always_comb begin
        case (i_ctl.jsel)
            J_ZERO:      n_j = '0;
            J_CHILD_INS: n_j = j_child;
            J_2J1:       n_j = {r_j[IW-2:0], 1'b0} + IW'(1);
            J_2J2:       n_j = {r_j[IW-2:0], 1'b0} + IW'(2);
            J_2I1:       n_j = {r_i[IW-2:0], 1'b0} + IW'(1);
            J_IM1:       n_j = r_i - IW'(1);
            J_I:         n_j = r_i;
            J_NEXT:      n_j = r_next;
            J_LEVEL:     n_j = lv_j;
            default:     n_j = r_j;
        endcase
        case (i_ctl.isel)
            I_J:     n_i = r_j;
            I_P:     n_i = par;
            default: n_i = r_i;
        endcase
    end

    // Store write port: clearing pass or insert.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_j[AW-1:0];
        mem_wd = {1'b1, r_key};
        if (i_ctl.clear_en) begin
            mem_we = 1'b1;
            mem_wa = r_clr;
            mem_wd = '0;
        end else if (i_ctl.osel == O_INSERT && o_stat.j_in_range) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_q <= r_mem[r_j[AW-1:0]];
    end

    // Clearing pass counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_ctl.clear_en) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    // Index, key and result registers.
    always_ff @(posedge i_clk) begin
        r_j <= n_j;
        r_i <= n_i;
        if (i_ctl.key_load) begin
            r_key <= KEY_WIDTH'(i_key);
        end
        if (i_ctl.kbuf_load) begin
            r_kbuf <= $signed(r_q[KEY_WIDTH-1:0]);
        end
        case (i_ctl.nsel)
            N_I: begin
                r_next      <= r_i;
                r_next_none <= 1'b0;
            end
            N_J: begin
                r_next      <= r_j;
                r_next_none <= 1'b0;
            end
            N_P: begin
                r_next      <= par;
                r_next_none <= 1'b0;
            end
            N_NONE: begin
                r_next_none <= 1'b1;
            end
            default: begin
            end
        endcase
        case (i_ctl.osel)
            O_INSERT: begin
                r_out_key <= '0;
                r_status  <= o_stat.j_in_range ? STAT_OK : STAT_DROP;
                r_last    <= 1'b0;
            end
            O_END: begin
                r_out_key <= '0;
                r_status  <= STAT_END;
                r_last    <= 1'b0;
            end
            O_KEY: begin
                r_out_key <= 32'(r_kbuf);
                r_status  <= STAT_OK;
                r_last    <= r_next_none;
            end
            default: begin
            end
        endcase
    end

    assign o_out_key = r_out_key;
    assign o_status  = r_status;
    assign o_last    = r_last;

endmodule

[rtl/core/abst_ctrl.sv]
`timescale 1ns / 1ps

module abst_ctrl
    import abst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_op,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_wr_data,
    input  t_stat      i_stat,
    output t_ctl       o_ctl
);

    t_state     r_state, n_state;
    t_state     r_ret, n_ret;
    logic       r_in_next, n_in_next;
    logic       r_started, n_started;
    logic       r_done, n_done;
    logic       r_out_valid, n_out_valid;
    logic [1:0] r_order;
    logic       in_acc;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE) || r_out_valid;
    assign o_out_valid = r_out_valid;

    // Next state and traversal flags.
    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_in_next   = r_in_next;
        n_started   = r_started;
        n_done      = r_done;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_in_next = 1'b0;
                    if (i_op == OP_INSERT) begin
                        n_started = 1'b0;
                        n_done    = 1'b0;
                        n_ret     = S_INS;
                        n_state   = S_WAIT;
                    end else if (!r_started) begin
                        n_started = 1'b1;
                        n_ret     = S_ROOT;
                        n_state   = S_WAIT;
                    end else if (r_done || i_stat.next_none) begin
                        n_done      = 1'b1;
                        n_out_valid = 1'b1;
                    end else begin
                        n_ret   = S_KEY;
                        n_state = S_WAIT;
                    end
                end
            end
            S_WAIT: n_state = r_ret;
            S_INS: begin
                if (i_stat.occ) begin
                    n_state = S_WAIT;
                end else begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_ROOT: begin
                if (!i_stat.occ) begin
                    n_done      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else if (r_order == ORD_IN) begin
                    n_ret   = S_FC;
                    n_state = S_WAIT;
                end else if (r_order == ORD_POST) begin
                    n_ret   = S_PDA;
                    n_state = S_WAIT;
                end else begin
                    n_state = S_KEY;
                end
            end
            S_FC, S_PDB: begin
                if (i_stat.occ) begin
                    n_ret   = (r_state == S_FC) ? S_FC : S_PDA;
                    n_state = S_WAIT;
                end else if (r_in_next) begin
                    n_state = S_EMIT;
                end else begin
                    n_ret   = S_KEY;
                    n_state = S_WAIT;
                end
            end
            S_PDA: begin
                n_ret   = i_stat.occ ? S_PDA : S_PDB;
                n_state = S_WAIT;
            end
            S_KEY: begin
                n_in_next = 1'b1;
                n_state   = S_NEXT;
            end
            S_NEXT: begin
                case (r_order)
                    ORD_IN: begin
                        n_ret   = S_INX;
                        n_state = S_WAIT;
                    end
                    ORD_PRE: begin
                        n_ret   = S_PRA;
                        n_state = S_WAIT;
                    end
                    ORD_POST: n_state = S_PO;
                    default:  n_state = S_LVSTEP;
                endcase
            end
            S_INX: begin
                if (i_stat.occ) begin
                    n_ret   = S_FC;
                    n_state = S_WAIT;
                end else begin
                    n_state = S_INUP;
                end
            end
            S_INUP: begin
                if (i_stat.i_zero || i_stat.i_even) begin
                    n_state = S_EMIT;
                end
            end
            S_PRA: begin
                if (i_stat.occ) begin
                    n_state = S_EMIT;
                end else begin
                    n_ret   = S_PRB;
                    n_state = S_WAIT;
                end
            end
            S_PRB: n_state = i_stat.occ ? S_EMIT : S_PRUP;
            S_PRUP: begin
                if (i_stat.i_zero) begin
                    n_state = S_EMIT;
                end else if (i_stat.i_even) begin
                    n_ret   = S_PRC;
                    n_state = S_WAIT;
                end
            end
            S_PRC: n_state = i_stat.occ ? S_EMIT : S_PRUP;
            S_PO: begin
                if (!i_stat.i_zero && i_stat.i_even) begin
                    n_ret   = S_POX;
                    n_state = S_WAIT;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_POX: begin
                if (i_stat.occ) begin
                    n_ret   = S_PDA;
                    n_state = S_WAIT;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_LVSTEP: begin
                if (i_stat.lv_end) begin
                    n_state = S_EMIT;
                end else begin
                    n_ret   = S_LV;
                    n_state = S_WAIT;
                end
            end
            S_LV: n_state = i_stat.occ ? S_EMIT : S_LVSTEP;
            S_EMIT: begin
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_ctl = '{jsel: J_HOLD, isel: I_HOLD, nsel: N_HOLD, osel: O_HOLD,
                  key_load: 1'b0, kbuf_load: 1'b0, clear_en: 1'b0};
        case (r_state)
            S_CLEAR: o_ctl.clear_en = 1'b1;
            S_IDLE: begin
                if (in_acc) begin
                    if (i_op == OP_INSERT) begin
                        o_ctl.key_load = 1'b1;
                        o_ctl.jsel     = J_ZERO;
                    end else if (!r_started) begin
                        o_ctl.jsel = J_ZERO;
                    end else if (r_done || i_stat.next_none) begin
                        o_ctl.osel = O_END;
                    end else begin
                        o_ctl.jsel = J_NEXT;
                    end
                end
            end
            S_INS: begin
                if (i_stat.occ) begin
                    o_ctl.jsel = J_CHILD_INS;
                end else begin
                    o_ctl.osel = O_INSERT;
                end
            end
            S_ROOT: begin
                if (!i_stat.occ) begin
                    o_ctl.osel = O_END;
                end else if (r_order == ORD_IN || r_order == ORD_POST) begin
                    o_ctl.isel = I_J;
                    o_ctl.jsel = J_2J2;
                end
            end
            S_FC, S_PDB: begin
                if (i_stat.occ) begin
                    o_ctl.isel = I_J;
                    o_ctl.jsel = J_2J2;
                end else if (r_in_next) begin
                    o_ctl.nsel = N_I;
                end else begin
                    o_ctl.jsel = J_I;
                end
            end
            S_PDA: begin
                if (i_stat.occ) begin
                    o_ctl.isel = I_J;
                    o_ctl.jsel = J_2J2;
                end else begin
                    o_ctl.jsel = J_2I1;
                end
            end
            S_KEY: o_ctl.kbuf_load = 1'b1;
            S_NEXT: begin
                o_ctl.isel = I_J;
                if (r_order == ORD_IN) begin
                    o_ctl.jsel = J_2J1;
                end else if (r_order == ORD_PRE) begin
                    o_ctl.jsel = J_2J2;
                end
            end
            S_INX: begin
                if (i_stat.occ) begin
                    o_ctl.isel = I_J;
                    o_ctl.jsel = J_2J2;
                end
            end
            S_INUP: begin
                if (i_stat.i_zero) begin
                    o_ctl.nsel = N_NONE;
                end else if (i_stat.i_even) begin
                    o_ctl.nsel = N_P;
                end else begin
                    o_ctl.isel = I_P;
                end
            end
            S_PRA: begin
                if (i_stat.occ) begin
                    o_ctl.nsel = N_J;
                end else begin
                    o_ctl.jsel = J_2I1;
                end
            end
            S_PRB: begin
                if (i_stat.occ) begin
                    o_ctl.nsel = N_J;
                end
            end
            S_PRUP: begin
                if (i_stat.i_zero) begin
                    o_ctl.nsel = N_NONE;
                end else if (i_stat.i_even) begin
                    o_ctl.jsel = J_IM1;
                end else begin
                    o_ctl.isel = I_P;
                end
            end
            S_PRC: begin
                if (i_stat.occ) begin
                    o_ctl.nsel = N_J;
                end else begin
                    o_ctl.isel = I_P;
                end
            end
            S_PO: begin
                if (i_stat.i_zero) begin
                    o_ctl.nsel = N_NONE;
                end else if (i_stat.i_even) begin
                    o_ctl.jsel = J_IM1;
                end else begin
                    o_ctl.nsel = N_P;
                end
            end
            S_POX: begin
                if (i_stat.occ) begin
                    o_ctl.isel = I_J;
                    o_ctl.jsel = J_2J2;
                end else begin
                    o_ctl.nsel = N_P;
                end
            end
            S_LVSTEP: begin
                if (i_stat.lv_end) begin
                    o_ctl.nsel = N_NONE;
                end else begin
                    o_ctl.jsel = J_LEVEL;
                end
            end
            S_LV: begin
                if (i_stat.occ) begin
                    o_ctl.nsel = N_J;
                end
            end
            S_EMIT: o_ctl.osel = O_KEY;
            default: begin
            end
        endcase
    end

    // State, flags and the order register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ret       <= S_IDLE;
            r_in_next   <= 1'b0;
            r_started   <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
            r_order     <= ORD_IN;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_in_next   <= n_in_next;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_order   <= i_cfg_wr_data;
                r_started <= 1'b0;
                r_done    <= 1'b0;
            end else begin
                r_started <= n_started;
                r_done    <= n_done;
            end
        end
    end

    // The input side takes nothing during the clearing pass.
    a_clear_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !in_acc && !r_out_valid)
        else $error("item taken during clearing pass");

    // A new item is only taken once the previous result has been transferred.
    a_accept_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> !r_out_valid)
        else $error("item taken while a result waits");

    // A finished traversal must have been started.
    a_done_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_started)
        else $error("traversal finished without start");

    // A key is only emitted within a started traversal.
    a_emit_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_started && r_in_next)
        else $error("key emitted outside a traversal");

    // A result appears only when work ends.
    a_result_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> r_state == S_IDLE)
        else $error("result raised while busy");

endmodule

[rtl/core/array_binary_search_tree.sv]
`timescale 1ns / 1ps
// An insert probes slots from the root down until it finds a free slot or leaves the store;
// a fetch steps through the slots of the selected order, climbing levels where needed.
// One item is handled at a time; the next is taken the cycle after the result transfers,
// as the slot store has one read port and each probe uses it in turn.
// Reset: synchronous, active low; a clearing pass then empties
// the store, and no item is taken until it ends.

module array_binary_search_tree
    import abst_pkg::*;
#(
    parameter int NODES     = 2048,
    parameter int KEY_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic signed [31:0] i_key,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_out_key,
    output logic [1:0]         o_status,
    output logic               o_last,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_wr_data
);

    t_ctl  ctl;
    t_stat stat;

    // Sequencer for inserts and traversal steps.
    abst_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_stat        (stat),
        .o_ctl         (ctl)
    );

    // Slot store, index arithmetic and result registers.
    abst_datapath #(
        .NODES     (NODES),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_key     (i_key),
        .o_stat    (stat),
        .o_out_key (o_out_key),
        .o_status  (o_status),
        .o_last    (o_last)
    );

endmodule
